>>> hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Opcodes, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_FINISH  = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } cmd_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [255:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> hdl/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts items, drops ignored ones and queues the rest for the engine.
// ----------------------------------------------------------------------------
module sha256_front #(
    parameter int DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic [1:0]         op,
    input  logic [7:0]         data_byte,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output sha256_pkg::cmd_t   cmd
);
    localparam int AW = $clog2(DEPTH);

    sha256_pkg::cmd_t       q_reg [DEPTH];
    logic [AW-1:0]          wp_reg;
    logic [AW-1:0]          rp_reg;
    logic [AW:0]            cnt_reg;
    logic                   done_reg;
    logic                   take;
    logic                   push;
    logic                   pop;

    assign ready     = (cnt_reg != DEPTH[AW:0]);
    assign take      = valid && ready;
    assign push      = take && (op == sha256_pkg::OP_RESTART ||
                       (!done_reg && (op == sha256_pkg::OP_BYTE ||
                                      op == sha256_pkg::OP_FINISH)));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].kind <= op;
            q_reg[wp_reg].data <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
            if (take && op == sha256_pkg::OP_RESTART)
                done_reg <= 1'b0;
            else if (push && op == sha256_pkg::OP_FINISH)
                done_reg <= 1'b1;
        end
    end
endmodule

>>> hdl/sha256_back.sv
// ----------------------------------------------------------------------------
// SHA-256 engine
// Buffers bytes, pads, runs one round per cycle and emits the digest.
// ----------------------------------------------------------------------------
module sha256_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  sha256_pkg::cmd_t   cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_ROUND, S_ADD, S_PAD, S_EMIT
    } state_t;

    state_t          state_reg;
    logic [511:0]    buf_reg;
    logic [511:0]    w_reg;
    logic [255:0]    h_reg;
    logic [255:0]    v_reg;
    logic [63:0]     count_reg;
    logic [5:0]      round_reg;
    logic [2:0]      idx_reg;
    logic            fin_reg;
    logic            second_reg;

    logic [31:0] wt, a, b, c, d, e, f, g, hh, t1, t2, w2, w15, s0, s1;
    logic [5:0]  pos;
    logic [511:0] pad_blk;
    logic [63:0] bits;

    assign pos  = count_reg[5:0];
    assign bits = {count_reg[60:0], 3'b000};

    always_comb
    begin
        w2  = w_reg[32*14 +: 32];
        w15 = w_reg[32*1 +: 32];
        s0  = sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3);
        s1  = sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10);
        if (round_reg < 6'd16)
            wt = buf_reg[511 - 32*round_reg -: 32];
        else
            wt = s1 + w_reg[32*9 +: 32] + s0 + w_reg[0 +: 32];
        {a, b, c, d, e, f, g, hh} = v_reg;
        t1 = hh + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25))
             + ((e & f) ^ (~e & g)) + sha256_pkg::round_k(round_reg) + wt;
        t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
    end

    always_comb
    begin
        pad_blk = buf_reg;
        for (int i = 0; i < 64; i++)
        begin
            if (i == int'(pos))
                pad_blk[511 - 8*i -: 8] = 8'h80;
            else if (i > int'(pos))
                pad_blk[511 - 8*i -: 8] = 8'h00;
        end
        if (pos < 6'd56)
            pad_blk[63:0] = bits;
    end

    assign cmd_ready   = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_EMIT);
    assign digest_word = h_reg[255 - 32*idx_reg -: 32];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            buf_reg    <= '0;
            h_reg      <= sha256_pkg::IV;
            count_reg  <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            v_reg      <= '0;
            w_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.kind)
                            sha256_pkg::OP_RESTART:
                            begin
                                buf_reg   <= '0;
                                h_reg     <= sha256_pkg::IV;
                                count_reg <= '0;
                            end
                            sha256_pkg::OP_BYTE:
                            begin
                                buf_reg[511 - 8*pos -: 8] <= cmd.data;
                                count_reg <= count_reg + 64'd1;
                                if (pos == 6'h3F)
                                begin
                                    v_reg     <= h_reg;
                                    round_reg <= '0;
                                    fin_reg   <= 1'b0;
                                    state_reg <= S_ROUND;
                                end
                            end
                            sha256_pkg::OP_FINISH:
                            begin
                                state_reg <= S_PAD;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PAD:
                begin
                    v_reg     <= h_reg;
                    round_reg <= '0;
                    fin_reg   <= 1'b1;
                    if (second_reg)
                    begin
                        buf_reg    <= {448'd0, bits};
                        second_reg <= 1'b0;
                    end
                    else
                    begin
                        buf_reg    <= pad_blk;
                        second_reg <= (pos >= 6'd56);
                    end
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    w_reg     <= {wt, w_reg[511:32]};
                    v_reg     <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[32*i +: 32] <= h_reg[32*i +: 32] + v_reg[32*i +: 32];
                    idx_reg <= '0;
                    if (!fin_reg)
                        state_reg <= S_IDLE;
                    else if (second_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with finish and restart commands.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): op and data_byte. op 0 adds a byte, op 1 pads
// the message and emits the digest, op 2 restarts the hash. Bytes and
// finishes after a finish are dropped until a restart; op 3 is dropped.
// Output channel (valid/ready): eight digest words, word_index 0..7, with
// last_word set on the eighth.
// A four-entry queue separates the input from the engine. Every 64th byte
// starts a compression in the one-round-per-cycle compression unit; the
// engine takes no new items until it is done. A finish pads the message,
// compresses one or two blocks, then emits one digest word per cycle while
// the receiver is ready. A stalled receiver holds the current word and the
// engine; the queue keeps taking items until it fills. Reset loads the
// initial hash values and clears the count, buffer and queue.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core #(
    parameter int QDEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    logic             cmd_valid;
    logic             cmd_ready;
    sha256_pkg::cmd_t cmd;

    sha256_front #(.DEPTH(QDEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .ready     (in_ready),
        .op        (op),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sha256_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );
endmodule
